/* hdl/gradient_color_ramp_lookup_defines.svh */
// ----------------------------------------------------------------------------
// gradient color ramp lookup assertion macros
// concurrent assertion helpers used by grl_back of the ramp lookup rtl
// ----------------------------------------------------------------------------
`ifndef GRADIENT_COLOR_RAMP_LOOKUP_DEFINES_SVH
`define GRADIENT_COLOR_RAMP_LOOKUP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ramp lookup assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ramp lookup assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/grl_pkg.sv */
// ----------------------------------------------------------------------------
// grl_pkg
// shared constants and types of the gradient color ramp lookup
// ----------------------------------------------------------------------------
package grl_pkg;

    localparam int MARK_SLOTS  = 8;
    localparam int POS_BITS    = 16;
    localparam int SLOT_BITS   = 3;
    localparam int COLOR_BITS  = 8;
    localparam int SLOT_IDX_W  = (MARK_SLOTS > 1) ? $clog2(MARK_SLOTS) : 1;
    localparam int SLOT_CMP_W  = ((SLOT_BITS > SLOT_IDX_W) ? SLOT_BITS : SLOT_IDX_W) + 1;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SETUP,
        S_DIV,
        S_BLEND,
        S_DONE
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [SLOT_IDX_W-1:0]  slot;
        logic                   enable;
        logic [POS_BITS-1:0]    pos;
        logic [COLOR_BITS-1:0]  red;
        logic [COLOR_BITS-1:0]  green;
        logic [COLOR_BITS-1:0]  blue;
    } t_cmd;

endpackage

/* hdl/gradient_color_ramp_lookup.sv */
// ----------------------------------------------------------------------------
// gradient_color_ramp_lookup
// color ramp of up to eight marks with linear interpolation between them
// ----------------------------------------------------------------------------
// input side is a queue: drive the request fields with push high while full is
// low. kind 0 writes or removes one mark slot and gives no result; kind 1
// queries the color at position and gives one result.
// result side is a queue: while empty is low the oldest result sits on the
// out ports and pop takes it.
// requests pass an input register and a two deep command queue before they
// reach the back end; the back end runs them one at a time.
// a write updates its mark slot as it is popped and leaves the back end idle.
// a query with marks on both sides runs one slot compare per cycle, one
// quotient bit per cycle over POS_BITS + 1 bits, one channel multiply per
// cycle, then the hand-off to the result register. a query with marks on one
// side only, or none, skips the divide and blend.
// a waiting result does not block the next query; a query that finishes
// while the result register is still full waits until pop.
// reset clears all mark slots, queues and the result register.
// ----------------------------------------------------------------------------
module gradient_color_ramp_lookup import grl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_kind,
    input  logic [SLOT_BITS-1:0]   i_slot,
    input  logic                   i_mark_enable,
    input  logic [POS_BITS-1:0]    i_position,
    input  logic [COLOR_BITS-1:0]  i_in_red,
    input  logic [COLOR_BITS-1:0]  i_in_green,
    input  logic [COLOR_BITS-1:0]  i_in_blue,
    output logic                   empty,
    input  logic                   pop,
    output logic [COLOR_BITS-1:0]  o_out_red,
    output logic [COLOR_BITS-1:0]  o_out_green,
    output logic [COLOR_BITS-1:0]  o_out_blue,
    output logic                   o_any_mark
);

    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_empty;
    t_cmd w_front_cmd;
    t_cmd w_back_cmd;

    grl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_mark_enable (i_mark_enable),
        .i_position    (i_position),
        .i_red         (i_in_red),
        .i_green       (i_in_green),
        .i_blue        (i_in_blue),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_cmd         (w_front_cmd)
    );

    grl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_back_cmd),
        .o_empty (w_q_empty)
    );

    grl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_cmd     (w_back_cmd),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_any     (o_any_mark)
    );

endmodule

/* hdl/grl_front.sv */
// ----------------------------------------------------------------------------
// grl_front
// input register that takes requests, drops out of range writes and
// hands the rest to the command queue
// ----------------------------------------------------------------------------
module grl_front import grl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic                   i_kind,
    input  logic [SLOT_BITS-1:0]   i_slot,
    input  logic                   i_mark_enable,
    input  logic [POS_BITS-1:0]    i_position,
    input  logic [COLOR_BITS-1:0]  i_red,
    input  logic [COLOR_BITS-1:0]  i_green,
    input  logic [COLOR_BITS-1:0]  i_blue,
    input  logic                   i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd w_cmd;
    logic w_take;
    logic w_keep;
    logic w_slot_ok;

    assign o_full   = r_valid && i_q_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_cmd    = r_cmd;
    assign w_take   = i_push && !o_full;

    assign w_slot_ok = SLOT_CMP_W'(i_slot) < SLOT_CMP_W'(MARK_SLOTS);
    assign w_keep    = (t_kind'(i_kind) == KIND_QUERY) || w_slot_ok;

    always_comb begin
        w_cmd.kind   = t_kind'(i_kind);
        w_cmd.slot   = SLOT_IDX_W'(i_slot);
        w_cmd.enable = i_mark_enable;
        w_cmd.pos    = POS_BITS'(i_position);
        w_cmd.red    = i_red;
        w_cmd.green  = i_green;
        w_cmd.blue   = i_blue;
    end

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = w_keep;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

/* hdl/grl_fifo.sv */
// ----------------------------------------------------------------------------
// grl_fifo
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
module grl_fifo import grl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_cmd  o_data,
    output logic  o_empty
);

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = r_count == FIFO_CNT_W'(FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] ptr);
        if (ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (w_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/grl_back.sv */
// ----------------------------------------------------------------------------
// grl_back
// mark table, slot scan, iterative divider, channel blend and result register
// ----------------------------------------------------------------------------
`include "gradient_color_ramp_lookup_defines.svh"

module grl_back import grl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_cmd                   i_cmd,
    output logic                   o_q_pop,
    output logic                   o_empty,
    input  logic                   i_pop,
    output logic [COLOR_BITS-1:0]  o_red,
    output logic [COLOR_BITS-1:0]  o_green,
    output logic [COLOR_BITS-1:0]  o_blue,
    output logic                   o_any
);

    localparam int COL_W     = 3 * COLOR_BITS;
    localparam int Q_W       = POS_BITS + 1;
    localparam int DIV_CNT_W = $clog2(POS_BITS + 1);
    localparam int ACC_W     = POS_BITS + COLOR_BITS + 3;
    localparam int POS_ONE   = 1 << POS_BITS;
    localparam int POS_HALF  = 1 << (POS_BITS - 1);

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    t_state                  r_state;
    t_state                  n_state;
    logic                    r_valid [MARK_SLOTS];
    logic [POS_BITS-1:0]     r_pos   [MARK_SLOTS];
    logic [COL_W-1:0]        r_col   [MARK_SLOTS];

    logic [SLOT_IDX_W-1:0]   r_idx;
    logic                    r_lo_found;
    logic                    r_hi_found;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    t_chan                   r_ch;
    logic                    r_out_valid;

    logic [POS_BITS-1:0]     r_p;
    logic [POS_BITS-1:0]     r_lo_pos;
    logic [POS_BITS-1:0]     r_hi_pos;
    logic [COL_W-1:0]        r_lo_col;
    logic [COL_W-1:0]        r_hi_col;
    logic [Q_W-1:0]          r_rem;
    logic [POS_BITS-1:0]     r_dist;
    logic [Q_W-1:0]          r_q;
    logic [COL_W-1:0]        r_res_col;
    logic                    r_res_any;
    logic [COL_W-1:0]        r_out_col;
    logic                    r_out_any;

    logic                    w_scan_last;
    logic                    w_out_free;
    logic                    w_load_out;
    logic                    w_start;
    logic [POS_BITS-1:0]     w_mp;
    logic                    w_take_lo;
    logic                    w_take_hi;
    logic                    w_ge;
    logic [Q_W-1:0]          w_sub;
    logic [COLOR_BITS-1:0]   w_lc;
    logic [COLOR_BITS-1:0]   w_hc;
    logic signed [COLOR_BITS:0]   w_diff;
    logic signed [POS_BITS+1:0]   w_dsgn;
    logic signed [ACC_W-1:0]      w_acc;
    logic [COLOR_BITS-1:0]   w_chan;

    assign o_empty     = !r_out_valid;
    assign o_red       = r_out_col[2*COLOR_BITS +: COLOR_BITS];
    assign o_green     = r_out_col[COLOR_BITS +: COLOR_BITS];
    assign o_blue      = r_out_col[0 +: COLOR_BITS];
    assign o_any       = r_out_any;
    assign w_out_free  = !r_out_valid || i_pop;
    assign w_scan_last = r_idx == SLOT_IDX_W'(MARK_SLOTS - 1);

    // scan compare
    assign w_mp      = r_pos[r_idx];
    assign w_take_lo = r_valid[r_idx] && (w_mp < r_p) && (!r_lo_found || (r_lo_pos < w_mp));
    assign w_take_hi = r_valid[r_idx] && !(w_mp < r_p) &&
                       (!r_hi_found || (r_hi_pos > w_mp));

    // restoring divide step
    assign w_ge  = r_rem >= Q_W'(r_dist);
    assign w_sub = w_ge ? (r_rem - Q_W'(r_dist)) : r_rem;

    // blend: lo*S + (hi-lo)*delta + S/2
    always_comb begin
        case (r_ch)
            CH_RED: begin
                w_lc = r_lo_col[2*COLOR_BITS +: COLOR_BITS];
                w_hc = r_hi_col[2*COLOR_BITS +: COLOR_BITS];
            end
            CH_GREEN: begin
                w_lc = r_lo_col[COLOR_BITS +: COLOR_BITS];
                w_hc = r_hi_col[COLOR_BITS +: COLOR_BITS];
            end
            default: begin
                w_lc = r_lo_col[0 +: COLOR_BITS];
                w_hc = r_hi_col[0 +: COLOR_BITS];
            end
        endcase
    end

    assign w_diff = $signed({1'b0, w_hc}) - $signed({1'b0, w_lc});
    assign w_dsgn = $signed({1'b0, r_q});
    assign w_acc  = ACC_W'(w_diff) * ACC_W'(w_dsgn)
                  + $signed(ACC_W'({w_lc, POS_BITS'(0)}))
                  + $signed(ACC_W'(POS_HALF));
    assign w_chan = w_acc[POS_BITS +: COLOR_BITS];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty && (i_cmd.kind == KIND_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = (r_lo_found && r_hi_found) ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (r_div_cnt == DIV_CNT_W'(POS_BITS)) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (r_ch == CH_BLUE) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_q_pop = !i_q_empty;
            end
            S_DONE: begin
                w_load_out = w_out_free;
            end
            default: begin
                o_q_pop    = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign w_start = o_q_pop && (i_cmd.kind == KIND_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_lo_found  <= 1'b0;
            r_hi_found  <= 1'b0;
            r_div_cnt   <= '0;
            r_ch        <= CH_RED;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MARK_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (o_q_pop && (i_cmd.kind == KIND_WRITE)) begin
                r_valid[i_cmd.slot] <= i_cmd.enable;
            end
            if (w_start) begin
                r_idx      <= '0;
                r_lo_found <= 1'b0;
                r_hi_found <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_idx <= w_scan_last ? '0 : r_idx + 1'b1;
                if (w_take_lo) begin
                    r_lo_found <= 1'b1;
                end
                if (w_take_hi) begin
                    r_hi_found <= 1'b1;
                end
            end
            if (r_state == S_SETUP) begin
                r_div_cnt <= '0;
                r_ch      <= CH_RED;
            end
            if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (r_state == S_BLEND) begin
                r_ch <= t_chan'(r_ch + 2'd1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && (i_cmd.kind == KIND_WRITE) && i_cmd.enable) begin
            r_pos[i_cmd.slot] <= i_cmd.pos;
            r_col[i_cmd.slot] <= {i_cmd.red, i_cmd.green, i_cmd.blue};
        end
        if (w_start) begin
            r_p <= i_cmd.pos;
        end
        if (r_state == S_SCAN) begin
            if (w_take_lo) begin
                r_lo_pos <= w_mp;
                r_lo_col <= r_col[r_idx];
            end
            if (w_take_hi) begin
                r_hi_pos <= w_mp;
                r_hi_col <= r_col[r_idx];
            end
        end
        if (r_state == S_SETUP) begin
            r_rem     <= Q_W'(r_p - r_lo_pos);
            r_dist    <= r_hi_pos - r_lo_pos;
            r_q       <= '0;
            r_res_any <= r_lo_found || r_hi_found;
            if (r_lo_found && !r_hi_found) begin
                r_res_col <= r_lo_col;
            end else if (r_hi_found && !r_lo_found) begin
                r_res_col <= r_hi_col;
            end else begin
                r_res_col <= '0;
            end
        end
        if (r_state == S_DIV) begin
            r_rem <= {w_sub[POS_BITS-1:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
        if (r_state == S_BLEND) begin
            case (r_ch)
                CH_RED:   r_res_col[2*COLOR_BITS +: COLOR_BITS] <= w_chan;
                CH_GREEN: r_res_col[COLOR_BITS +: COLOR_BITS]   <= w_chan;
                default:  r_res_col[0 +: COLOR_BITS]            <= w_chan;
            endcase
        end
        if (w_load_out) begin
            r_out_col <= r_res_col;
            r_out_any <= r_res_any;
        end
    end

    `ASSERT_IMPLIES(a_div_needs_both, i_clk, i_rst_n, r_state == S_DIV, r_lo_found && r_hi_found)
    `ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, (r_state == S_SCAN) && w_scan_last, r_state == S_SETUP)
    `ASSERT_IMPLIES(a_delta_range, i_clk, i_rst_n, r_state == S_BLEND, r_q <= Q_W'(POS_ONE))
    `ASSERT_NEXT(a_write_stays_idle, i_clk, i_rst_n, o_q_pop && (i_cmd.kind == KIND_WRITE), r_state == S_IDLE)

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for gradient_color_ramp_lookup. A software copy of the mark table
// predicts every query result, and a pop-side checker compares each field.
// Directed tests cover the empty ramp, a single mark, interpolation and
// equal-position marks. Random tests then run under four idle/stall settings.
// ----------------------------------------------------------------------------
module tb_top import grl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 64;
    localparam longint unsigned POS_ONE = longint'(1) << POS_BITS;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
        logic                  any_mark;
    } t_ramp_color;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_kind = 1'b0;
    logic [SLOT_BITS-1:0]  i_slot = '0;
    logic                  i_mark_enable = 1'b0;
    logic [15:0]           i_position = '0;
    logic [COLOR_BITS-1:0] i_in_red = '0;
    logic [COLOR_BITS-1:0] i_in_green = '0;
    logic [COLOR_BITS-1:0] i_in_blue = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [COLOR_BITS-1:0] o_out_red;
    logic [COLOR_BITS-1:0] o_out_green;
    logic [COLOR_BITS-1:0] o_out_blue;
    logic                  o_any_mark;

    logic                  mark_on [MARK_SLOTS];
    logic [POS_BITS-1:0]   mark_pos [MARK_SLOTS];
    logic [23:0]           mark_rgb [MARK_SLOTS];
    t_ramp_color           colors_due [$];

    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int mismatches = 0;
    int n_writes = 0;
    int n_removes = 0;
    int n_queries = 0;
    int n_checked = 0;
    int cycles = 0;

    gradient_color_ramp_lookup i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_slot        (i_slot),
        .i_mark_enable (i_mark_enable),
        .i_position    (i_position),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .empty         (empty),
        .pop           (pop),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_any_mark    (o_any_mark)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, colors_due.size());
            $display("gradient_color_ramp_lookup: mismatch");
            $finish;
        end
    end

    function automatic logic [COLOR_BITS-1:0] mix_channel(input logic [COLOR_BITS-1:0] lo_c,
                                                          input logic [COLOR_BITS-1:0] hi_c,
                                                          input longint unsigned frac);
        longint unsigned acc;
        acc = longint'(lo_c) * (POS_ONE - frac) + longint'(hi_c) * frac + (POS_ONE >> 1);
        return acc[POS_BITS +: COLOR_BITS];
    endfunction

    function automatic t_ramp_color ramp_color_at(input logic [POS_BITS-1:0] p);
        int              lo;
        int              hi;
        longint unsigned lp;
        longint unsigned hp;
        longint unsigned frac;
        t_ramp_color     res;
        lo = -1;
        hi = -1;
        res = '0;
        for (int s = 0; s < MARK_SLOTS; s++) begin
            if (mark_on[s]) begin
                if (mark_pos[s] < p) begin
                    if (lo < 0 || mark_pos[lo] < mark_pos[s]) lo = s;
                end else if (hi < 0 || mark_pos[hi] > mark_pos[s]) begin
                    hi = s;
                end
            end
        end
        if (lo < 0 && hi < 0) return res;
        if (lo < 0) lo = hi;
        if (hi < 0) hi = lo;
        res.any_mark = 1'b1;
        if (lo == hi) begin
            {res.red, res.green, res.blue} = mark_rgb[lo];
            return res;
        end
        lp = 64'(mark_pos[lo]);
        hp = 64'(mark_pos[hi]);
        frac = ((longint'(p) - lp) << POS_BITS) / (hp - lp);
        if (frac > POS_ONE) frac = POS_ONE;
        res.red   = mix_channel(mark_rgb[lo][23:16], mark_rgb[hi][23:16], frac);
        res.green = mix_channel(mark_rgb[lo][15:8], mark_rgb[hi][15:8], frac);
        res.blue  = mix_channel(mark_rgb[lo][7:0], mark_rgb[hi][7:0], frac);
        return res;
    endfunction

    function automatic t_cmd make_request(input t_kind k, input int s, input logic en,
                                          input logic [POS_BITS-1:0] p,
                                          input logic [23:0] rgb);
        t_cmd c;
        c.kind   = k;
        c.slot   = SLOT_IDX_W'(s);
        c.enable = en;
        c.pos    = p;
        c.red    = rgb[23:16];
        c.green  = rgb[15:8];
        c.blue   = rgb[7:0];
        return c;
    endfunction

    task automatic send_request(input t_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_kind        <= c.kind;
        i_slot        <= c.slot;
        i_mark_enable <= c.enable;
        i_position    <= c.pos;
        i_in_red      <= c.red;
        i_in_green    <= c.green;
        i_in_blue     <= c.blue;
        do @(posedge i_clk); while (full);
        if (c.kind == KIND_QUERY) begin
            colors_due.push_back(ramp_color_at(c.pos));
            n_queries++;
        end else if (c.enable) begin
            mark_on[c.slot]  = 1'b1;
            mark_pos[c.slot] = c.pos;
            mark_rgb[c.slot] = {c.red, c.green, c.blue};
            n_writes++;
        end else begin
            mark_on[c.slot] = 1'b0;
            n_removes++;
        end
    endtask

    task automatic write_mark(input int s, input logic [POS_BITS-1:0] p, input logic [23:0] rgb);
        send_request(make_request(KIND_WRITE, s, 1'b1, p, rgb));
    endtask

    task automatic remove_mark(input int s);
        send_request(make_request(KIND_WRITE, s, 1'b0, POS_BITS'($urandom), 24'($urandom)));
    endtask

    task automatic query_at(input logic [POS_BITS-1:0] p);
        send_request(make_request(KIND_QUERY, int'($urandom_range(7)),
                                  1'($urandom_range(1)), p, 24'($urandom)));
    endtask

    task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_ramp_color want;
        if (i_rst_n && pop && !empty) begin
            if (colors_due.size() == 0) begin
                $display("%0t unexpected result expected none actual %0h %0h %0h %0b",
                         $time, o_out_red, o_out_green, o_out_blue, o_any_mark);
                mismatches++;
            end else begin
                want = colors_due.pop_front();
                report_field("red", want.red, o_out_red);
                report_field("green", want.green, o_out_green);
                report_field("blue", want.blue, o_out_blue);
                report_field("any_mark", 8'(want.any_mark), 8'(o_any_mark));
                n_checked++;
            end
        end
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    function automatic logic [POS_BITS-1:0] pick_position();
        int s;
        s = $urandom_range(MARK_SLOTS - 1);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return mark_pos[s];
            4: return mark_pos[s] + POS_BITS'($urandom_range(2)) - POS_BITS'(1);
            5: return POS_BITS'(32'h8000 + $urandom_range(64) - 32);
            default: return POS_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_empty_ramp();
        query_at(16'h0000);
        query_at(16'h8000);
        query_at(16'hffff);
    endtask

    task automatic test_single_mark();
        write_mark(7, 16'h8000, 24'hff0080);
        query_at(16'h0000);
        query_at(16'h8000);
        query_at(16'hffff);
        remove_mark(7);
        query_at(16'h8000);
    endtask

    task automatic test_interpolation();
        write_mark(0, 16'h0000, 24'h00ff00);
        write_mark(3, 16'hffff, 24'hff00ff);
        query_at(16'h0000);
        query_at(16'h0001);
        query_at(16'h8000);
        query_at(16'hffff);
        write_mark(5, 16'h4000, 24'hff0000);
        write_mark(1, 16'h4000, 24'h0000ff);
        query_at(16'h3fff);
        query_at(16'h4000);
        query_at(16'h4001);
        remove_mark(1);
        remove_mark(0);
        query_at(16'h4000);
    endtask

    task automatic test_random_ramp(input int count, input int idle_pct, input int stall_pct);
        t_cmd c;
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            c.kind   = ($urandom_range(1) != 0) ? KIND_QUERY : KIND_WRITE;
            c.slot   = SLOT_IDX_W'($urandom_range(MARK_SLOTS - 1));
            c.enable = ($urandom_range(3) != 0);
            c.pos    = pick_position();
            c.red    = pick_channel();
            c.green  = pick_channel();
            c.blue   = pick_channel();
            send_request(c);
        end
    endtask

    initial begin
        for (int s = 0; s < MARK_SLOTS; s++) begin
            mark_on[s]  = 1'b0;
            mark_pos[s] = '0;
            mark_rgb[s] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_ramp();
        test_single_mark();
        test_interpolation();
        test_random_ramp(200, 0, 0);
        test_random_ramp(200, 81, 0);
        test_random_ramp(200, 0, 81);
        test_random_ramp(200, 12, 12);
        push <= 1'b0;
        while (colors_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("mark writes %0d, removes %0d, queries %0d, results checked %0d",
                 n_writes, n_removes, n_queries, n_checked);
        $display("idle settings: none, sender 81%%, receiver 81%%, both 12%%");
        if (mismatches == 0) begin
            $display("gradient_color_ramp_lookup: match");
        end else begin
            $display("gradient_color_ramp_lookup: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/grl_pkg.sv
hdl/grl_front.sv
hdl/grl_fifo.sv
hdl/grl_back.sv
hdl/gradient_color_ramp_lookup.sv
verif/tb_top.sv
